// ----- rtl/mbrc_pkg.sv -----
package mbrc_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NORESP = 3'd1;
  localparam logic [2:0] ST_UNEXP  = 3'd2;
  localparam logic [2:0] ST_GAP    = 3'd3;
  localparam logic [2:0] ST_CRC    = 3'd4;
  localparam logic [2:0] ST_EXC    = 3'd5;

  localparam logic OUT_WORD   = 1'b0;
  localparam logic OUT_FINISH = 1'b1;

  localparam logic [2:0] REG_EXPECTED_SLAVE    = 3'd0;
  localparam logic [2:0] REG_EXPECTED_FUNCTION = 3'd1;
  localparam logic [2:0] REG_FRAME_MODE        = 3'd2;
  localparam logic [2:0] REG_FIRST_TIMEOUT     = 3'd3;
  localparam logic [2:0] REG_GAP_TIMEOUT       = 3'd4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [23:0] TIMER_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  expected_slave;
    logic [6:0]  expected_function;
    logic        frame_mode;
    logic [23:0] first_byte_timeout;
    logic [15:0] gap_timeout;
  } cfg_t;

  typedef struct packed {
    logic        out_kind;
    logic [2:0]  status;
    logic [7:0]  exception_code;
    logic [15:0] data_word;
    logic [6:0]  word_index;
    logic [6:0]  word_count;
  } res_t;

endpackage

// ----- rtl/mbrc_front.sv -----
module mbrc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,
  input  logic [1:0]     s_tuser,
  output logic           q_valid,
  output mbrc_pkg::item_t q_item,
  input  logic           q_ready
);

  mbrc_pkg::item_t slots [mbrc_pkg::QDEPTH];
  logic [mbrc_pkg::QPTR_W-1:0] wr_ptr;
  logic [mbrc_pkg::QPTR_W-1:0] rd_ptr;
  logic [mbrc_pkg::QPTR_W:0]   count;
  logic push;
  logic pop;

  assign s_tready = (count != (mbrc_pkg::QPTR_W + 1)'(mbrc_pkg::QDEPTH));
  // drop reserved kinds at intake
  assign push     = s_tvalid && s_tready && (s_tuser != mbrc_pkg::KIND_RSVD);
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{kind: s_tuser, rx_byte: s_tdata};
    end
  end

endmodule

// ----- rtl/mbrc_back.sv -----
module mbrc_back (
  input  logic            clk,
  input  logic            rst,
  input  mbrc_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  mbrc_pkg::item_t q_item,
  output logic            q_ready,
  output logic            res_valid,
  output mbrc_pkg::res_t  res,
  input  logic            res_ready
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ADDR, PH_FUNC, PH_EXC, PH_COUNT,
    PH_HI, PH_LO, PH_CRC_LO, PH_CRC_HI
  } phase_t;

  phase_t         phase, phase_next;
  logic [15:0]    running_crc, running_crc_next;
  logic [7:0]     bytes_left, bytes_left_next;
  logic [7:0]     high_byte_hold, high_byte_hold_next;
  logic [7:0]     received_crc_low, received_crc_low_next;
  logic [6:0]     words_done, words_done_next;
  logic [23:0]    wait_timer, wait_timer_next;
  logic           emit;
  mbrc_pkg::res_t res_next;

  logic        advance;
  logic        take;
  logic [15:0] crc_fed;
  logic [23:0] timer_inc;
  logic [23:0] limit;
  logic [7:0]  b;
  logic [7:0]  left_dec;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] d);
    logic [15:0] c;
    c = crc_in ^ {8'd0, d};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ mbrc_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  assign advance  = !res_valid || res_ready;
  assign q_ready  = advance;
  assign take     = q_valid && advance;
  assign b        = q_item.rx_byte;
  assign crc_fed  = crc_feed(running_crc, b);
  assign timer_inc = (wait_timer == mbrc_pkg::TIMER_MAX) ? wait_timer : wait_timer + 24'd1;
  assign limit    = (phase == PH_ADDR) ? cfg.first_byte_timeout : {8'd0, cfg.gap_timeout};
  assign left_dec = bytes_left - 8'd1;

  always_comb begin
    phase_next            = phase;
    running_crc_next      = running_crc;
    bytes_left_next       = bytes_left;
    high_byte_hold_next   = high_byte_hold;
    received_crc_low_next = received_crc_low;
    words_done_next       = words_done;
    wait_timer_next       = wait_timer;
    emit                  = 1'b0;
    res_next              = '0;
    res_next.word_count   = words_done;

    if (take) begin
      if (q_item.kind == mbrc_pkg::KIND_START) begin
        phase_next            = PH_ADDR;
        running_crc_next      = mbrc_pkg::CRC_INIT;
        bytes_left_next       = '0;
        high_byte_hold_next   = '0;
        received_crc_low_next = '0;
        words_done_next       = '0;
        wait_timer_next       = '0;
      end else if (phase != PH_IDLE && q_item.kind == mbrc_pkg::KIND_TICK) begin
        wait_timer_next = timer_inc;
        if (timer_inc >= limit) begin
          emit            = 1'b1;
          res_next.out_kind = mbrc_pkg::OUT_FINISH;
          res_next.status = (phase == PH_ADDR) ? mbrc_pkg::ST_NORESP : mbrc_pkg::ST_GAP;
          phase_next      = PH_IDLE;
          wait_timer_next = '0;
        end
      end else if (phase != PH_IDLE && q_item.kind == mbrc_pkg::KIND_BYTE) begin
        wait_timer_next = '0;
        if (phase != PH_CRC_LO && phase != PH_CRC_HI) begin
          running_crc_next = crc_fed;
        end
        unique case (phase)
          PH_ADDR: begin
            if (b != cfg.expected_slave) begin
              emit = 1'b1;
              res_next.out_kind = mbrc_pkg::OUT_FINISH;
              res_next.status   = mbrc_pkg::ST_UNEXP;
              phase_next        = PH_IDLE;
            end else begin
              phase_next = PH_FUNC;
            end
          end
          PH_FUNC: begin
            if (b[6:0] != cfg.expected_function) begin
              emit = 1'b1;
              res_next.out_kind = mbrc_pkg::OUT_FINISH;
              res_next.status   = mbrc_pkg::ST_UNEXP;
              phase_next        = PH_IDLE;
            end else if (b[7]) begin
              phase_next = PH_EXC;
            end else if (cfg.frame_mode) begin
              bytes_left_next = 8'd4;
              phase_next      = PH_HI;
            end else begin
              phase_next = PH_COUNT;
            end
          end
          PH_EXC: begin
            emit = 1'b1;
            res_next.out_kind       = mbrc_pkg::OUT_FINISH;
            res_next.status         = mbrc_pkg::ST_EXC;
            res_next.exception_code = b;
            phase_next              = PH_IDLE;
          end
          PH_COUNT: begin
            bytes_left_next = b;
            phase_next      = (b == 8'd0) ? PH_CRC_LO : PH_HI;
          end
          PH_HI: begin
            high_byte_hold_next = b;
            bytes_left_next     = left_dec;
            phase_next          = (left_dec == 8'd0) ? PH_CRC_LO : PH_LO;
          end
          PH_LO: begin
            emit = 1'b1;
            res_next.out_kind   = mbrc_pkg::OUT_WORD;
            res_next.data_word  = {high_byte_hold, b};
            res_next.word_index = words_done;
            res_next.word_count = '0;
            words_done_next     = words_done + 7'd1;
            bytes_left_next     = left_dec;
            phase_next          = (left_dec == 8'd0) ? PH_CRC_LO : PH_HI;
          end
          PH_CRC_LO: begin
            received_crc_low_next = b;
            phase_next            = PH_CRC_HI;
          end
          PH_CRC_HI: begin
            emit = 1'b1;
            res_next.out_kind = mbrc_pkg::OUT_FINISH;
            res_next.status   = (received_crc_low == running_crc[7:0] &&
                                 b == running_crc[15:8]) ? mbrc_pkg::ST_OK
                                                         : mbrc_pkg::ST_CRC;
            phase_next        = PH_IDLE;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
    if (!emit) begin
      res_next.word_count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      running_crc      <= mbrc_pkg::CRC_INIT;
      bytes_left       <= '0;
      high_byte_hold   <= '0;
      received_crc_low <= '0;
      words_done       <= '0;
      wait_timer       <= '0;
      res_valid        <= 1'b0;
    end else begin
      phase            <= phase_next;
      running_crc      <= running_crc_next;
      bytes_left       <= bytes_left_next;
      high_byte_hold   <= high_byte_hold_next;
      received_crc_low <= received_crc_low_next;
      words_done       <= words_done_next;
      wait_timer       <= wait_timer_next;
      if (advance) begin
        res_valid <= emit;
      end
    end
    if (advance) begin
      res <= res_next;
    end
  end

endmodule

// ----- rtl/modbus_rtu_response_checker_top.sv -----
// Modbus RTU response checker. After a start item (tuser 0) the block follows one slave
// response fed as received bytes (tuser 1) and microsecond ticks (tuser 2); tuser 3 is
// dropped. It sustains one transfer per clock while the output side keeps up: a four-entry
// queue separates the intake from the decode engine, and results sit in an output register,
// so an item's result passes through a queue slot and the output register. Payload words
// (master tuser 0) leave before the CRC is judged; discard them unless the closing status
// transfer (master tuser 1) reports ok. Exceptions finish without a CRC check and an odd
// last payload byte is dropped. Write configuration only while the block is idle.
module modbus_rtu_response_checker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // status[2:0], exception_code[10:3], data_word[26:11],
                                 // word_index[33:27], word_count[40:34], zero[47:41]
  output logic        m_tuser,   // out_kind
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  mbrc_pkg::cfg_t  cfg;
  mbrc_pkg::item_t q_item;
  mbrc_pkg::res_t  res;
  logic            q_valid;
  logic            q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_slave     <= 8'd1;
      cfg.expected_function  <= 7'd3;
      cfg.frame_mode         <= 1'b0;
      cfg.first_byte_timeout <= 24'd10000000;
      cfg.gap_timeout        <= 16'd1750;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbrc_pkg::REG_EXPECTED_SLAVE:    cfg.expected_slave     <= cfg_data[7:0];
        mbrc_pkg::REG_EXPECTED_FUNCTION: cfg.expected_function  <= cfg_data[6:0];
        mbrc_pkg::REG_FRAME_MODE:        cfg.frame_mode         <= cfg_data[0];
        mbrc_pkg::REG_FIRST_TIMEOUT:     cfg.first_byte_timeout <= cfg_data;
        mbrc_pkg::REG_GAP_TIMEOUT:       cfg.gap_timeout        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  mbrc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_ready  (q_ready)
  );

  mbrc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready),
    .res_valid (m_tvalid),
    .res       (res),
    .res_ready (m_tready)
  );

  assign m_tuser = res.out_kind;
  assign m_tdata = {7'd0, res.word_count, res.word_index, res.data_word,
                    res.exception_code, res.status};

endmodule

// ----- test/modbus_rtu_response_checker_top_tb.sv -----
module modbus_rtu_response_checker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbrc_pkg::*;

  typedef enum logic [3:0] {
    RX_IDLE, RX_ADDR, RX_FUNC, RX_EXC, RX_COUNT, RX_HI, RX_LO, RX_CRC_LO, RX_CRC_HI
  } rx_phase_t;

  typedef enum {
    SH_GOOD, SH_EXC, SH_BAD_CRC, SH_BAD_SLAVE, SH_BAD_FUNC, SH_GAP, SH_SILENT, SH_CUT, SH_NOISE
  } frame_shape_t;

  class reply_tracker;
    cfg_t        regs;
    rx_phase_t   phase;
    logic [15:0] crc_acc;
    logic [7:0]  bytes_left;
    logic [7:0]  hi_byte;
    logic [7:0]  crc_lo_seen;
    logic [6:0]  words_out;
    logic [23:0] ticks;
    res_t        frame_outputs[$];
    int          mismatches;

    function new();
      regs.expected_slave     = 8'd1;
      regs.expected_function  = 7'd3;
      regs.frame_mode         = 1'b0;
      regs.first_byte_timeout = 24'd10000000;
      regs.gap_timeout        = 16'd1750;
      phase       = RX_IDLE;
      crc_acc     = CRC_INIT;
      bytes_left  = '0;
      hi_byte     = '0;
      crc_lo_seen = '0;
      words_out   = '0;
      ticks       = '0;
      mismatches  = 0;
    endfunction

    static function logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        REG_EXPECTED_SLAVE:    regs.expected_slave     = val[7:0];
        REG_EXPECTED_FUNCTION: regs.expected_function  = val[6:0];
        REG_FRAME_MODE:        regs.frame_mode         = val[0];
        REG_FIRST_TIMEOUT:     regs.first_byte_timeout = val;
        REG_GAP_TIMEOUT:       regs.gap_timeout        = val[15:0];
        default: ;
      endcase
    endfunction

    function int tick_limit();
      return (phase == RX_ADDR) ? int'(regs.first_byte_timeout) : int'(regs.gap_timeout);
    endfunction

    function void close_frame(logic [2:0] st, logic [7:0] code);
      res_t r;
      r = '0;
      r.out_kind       = OUT_FINISH;
      r.status         = st;
      r.exception_code = code;
      r.word_count     = words_out;
      frame_outputs.push_back(r);
      phase = RX_IDLE;
      ticks = '0;
    endfunction

    function void take_item(logic [1:0] kind, logic [7:0] b);
      res_t        r;
      logic [23:0] lim;
      if (kind == KIND_START) begin
        phase       = RX_ADDR;
        crc_acc     = CRC_INIT;
        bytes_left  = '0;
        hi_byte     = '0;
        crc_lo_seen = '0;
        words_out   = '0;
        ticks       = '0;
        return;
      end
      if (phase == RX_IDLE || kind == KIND_RSVD) return;
      if (kind == KIND_TICK) begin
        lim = (phase == RX_ADDR) ? regs.first_byte_timeout : {8'h00, regs.gap_timeout};
        if (ticks != TIMER_MAX) ticks++;
        if (ticks >= lim) close_frame((phase == RX_ADDR) ? ST_NORESP : ST_GAP, 8'h00);
        return;
      end
      ticks = '0;
      if (phase != RX_CRC_LO && phase != RX_CRC_HI) crc_acc = crc_next(crc_acc, b);
      case (phase)
        RX_ADDR: begin
          if (b != regs.expected_slave) close_frame(ST_UNEXP, 8'h00);
          else phase = RX_FUNC;
        end
        RX_FUNC: begin
          if (b[6:0] != regs.expected_function) close_frame(ST_UNEXP, 8'h00);
          else if (b[7]) phase = RX_EXC;
          else if (regs.frame_mode) begin
            bytes_left = 8'd4;
            phase = RX_HI;
          end else phase = RX_COUNT;
        end
        RX_EXC: close_frame(ST_EXC, b);
        RX_COUNT: begin
          bytes_left = b;
          phase = (b == 8'd0) ? RX_CRC_LO : RX_HI;
        end
        RX_HI: begin
          hi_byte = b;
          bytes_left--;
          phase = (bytes_left == 8'd0) ? RX_CRC_LO : RX_LO;
        end
        RX_LO: begin
          r = '0;
          r.out_kind   = OUT_WORD;
          r.data_word  = {hi_byte, b};
          r.word_index = words_out;
          frame_outputs.push_back(r);
          words_out++;
          bytes_left--;
          phase = (bytes_left == 8'd0) ? RX_CRC_LO : RX_HI;
        end
        RX_CRC_LO: begin
          crc_lo_seen = b;
          phase = RX_CRC_HI;
        end
        RX_CRC_HI: begin
          if (crc_lo_seen == crc_acc[7:0] && b == crc_acc[15:8]) close_frame(ST_OK, 8'h00);
          else close_frame(ST_CRC, 8'h00);
        end
        default: ;
      endcase
    endfunction

    function void check_output(logic kind, logic [47:0] data);
      res_t got;
      res_t want;
      got.out_kind       = kind;
      got.status         = data[2:0];
      got.exception_code = data[10:3];
      got.data_word      = data[26:11];
      got.word_index     = data[33:27];
      got.word_count     = data[40:34];
      if (frame_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none outstanding: kind %0d tdata %h", $time, kind, data);
        return;
      end
      want = frame_outputs.pop_front();
      if (got.out_kind !== want.out_kind || got.status !== want.status ||
          got.exception_code !== want.exception_code || got.data_word !== want.data_word ||
          got.word_index !== want.word_index || got.word_count !== want.word_count ||
          data[47:41] !== 7'd0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp kind %0d st %0d exc %h word %h idx %0d cnt %0d",
                   $time, want.out_kind, want.status, want.exception_code, want.data_word,
                   want.word_index, want.word_count);
          $display("%0t:          got kind %0d st %0d exc %h word %h idx %0d cnt %0d pad %h",
                   $time, got.out_kind, got.status, got.exception_code, got.data_word,
                   got.word_index, got.word_count, data[47:41]);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // rx_byte[7:0]
  logic [1:0]  s_tuser = 2'd0;    // kind[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;           // status, exception_code, data_word, word_index, word_count
  logic        m_tuser;           // out_kind
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [23:0] cfg_data = 24'd0;

  reply_tracker sb = new();
  bit tx_calm;
  bit rx_calm;
  int rx_hold;
  int sent_items;

  modbus_rtu_response_checker_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5ns clk = ~clk;

  function automatic int pick_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        sb.check_output(m_tuser, m_tdata);
        rx_hold = pick_wait(rx_calm);
      end else if (rx_hold > 0) rx_hold--;
      m_tready <= (rx_hold == 0);
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
    int gap;
    gap = pick_wait(tx_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.take_item(kind, b);
    if (kind != KIND_RSVD) sent_items++;
  endtask

  task automatic send_bytes(input logic [7:0] q[$], input bit jitter);
    int n;
    foreach (q[i]) begin
      if (jitter && $urandom_range(0, 29) == 0) send_item(KIND_RSVD, 8'($urandom_range(0, 255)));
      if (jitter && $urandom_range(0, 5) == 0) begin
        n = sb.tick_limit() - 1;
        if (n > 3) n = 3;
        repeat ($urandom_range(0, n)) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
      end
      send_item(KIND_BYTE, q[i]);
    end
  endtask

  function automatic void add_crc(ref logic [7:0] q[$]);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (q[i]) c = reply_tracker::crc_next(c, q[i]);
    q.push_back(c[7:0]);
    q.push_back(c[15:8]);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic quiesce();
    if (sb.phase != RX_IDLE) begin
      send_item(KIND_START, 8'h00);
      send_item(KIND_BYTE, ~sb.regs.expected_slave);
    end
    s_tvalid <= 1'b0;
    while (sb.frame_outputs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_frame();
    logic [7:0]   fr[$];
    logic [7:0]   slave;
    logic [6:0]   fn;
    frame_shape_t sh;
    int           r;
    int           n;
    int           cut;
    r  = $urandom_range(0, 99);
    sh = (r < 45) ? SH_GOOD : (r < 55) ? SH_EXC : (r < 65) ? SH_BAD_CRC :
         (r < 71) ? SH_BAD_SLAVE : (r < 77) ? SH_BAD_FUNC : (r < 85) ? SH_GAP :
         (r < 91) ? SH_SILENT : (r < 95) ? SH_CUT : SH_NOISE;
    if (sh == SH_NOISE) begin
      repeat ($urandom_range(1, 4))
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      return;
    end
    send_item(KIND_START, 8'($urandom_range(0, 255)));
    if (sh == SH_SILENT) begin
      n = sb.tick_limit();
      if (n > 64) n = $urandom_range(0, 8);
      repeat (n) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
      return;
    end
    slave = sb.regs.expected_slave;
    fn    = sb.regs.expected_function;
    case (sh)
      SH_BAD_SLAVE: begin
        fr.push_back(slave ^ 8'($urandom_range(1, 255)));
        fr.push_back(8'($urandom_range(0, 255)));
      end
      SH_BAD_FUNC: begin
        fr.push_back(slave);
        fr.push_back({1'($urandom_range(0, 1)), fn ^ 7'($urandom_range(1, 127))});
      end
      SH_EXC: begin
        fr.push_back(slave);
        fr.push_back({1'b1, fn});
        fr.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        fr.push_back(slave);
        fr.push_back({1'b0, fn});
        if (sb.regs.frame_mode) n = 4;
        else begin
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 255) : $urandom_range(0, 10);
          fr.push_back(8'(n));
        end
        repeat (n) fr.push_back(8'($urandom_range(0, 255)));
        add_crc(fr);
        if (sh == SH_BAD_CRC) begin
          cut = $urandom_range(0, fr.size() - 1);
          fr[cut] = fr[cut] ^ (8'h01 << $urandom_range(0, 7));
        end
        if (sh == SH_GAP || sh == SH_CUT) begin
          cut = $urandom_range(1, fr.size() - 1);
          while (fr.size() > cut) fr.delete(fr.size() - 1);
        end
      end
    endcase
    send_bytes(fr, 1'b1);
    if (sh == SH_GAP) begin
      n = sb.tick_limit();
      if (n <= 64) repeat (n) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [7:0]  fr[$];
    logic [7:0]  slave;
    logic [6:0]  func;
    logic        mode;
    logic [23:0] first_to;
    logic [15:0] gap_to;
    int          goal;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // idle traffic, odd payload, exception, wrong slave, restart with empty payload and bad CRC
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_RSVD, 8'hA5);
    send_item(KIND_START, 8'h00);
    fr = '{8'h01, 8'h03, 8'h03, 8'h00, 8'hFF, 8'h5A};
    add_crc(fr);
    send_bytes(fr, 1'b0);
    send_item(KIND_START, 8'hFF);
    fr = '{8'h01, 8'h83, 8'hFF};
    send_bytes(fr, 1'b0);
    send_item(KIND_START, 8'h00);
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_START, 8'h00);
    send_item(KIND_START, 8'h00);
    fr = '{8'h01, 8'h03, 8'h00};
    add_crc(fr);
    fr[3] = fr[3] ^ 8'h80;
    send_bytes(fr, 1'b0);
    quiesce();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          slave = 8'h00; func = 7'h00; mode = 1'b0; first_to = 24'd1; gap_to = 16'd1;
        end
        1: begin
          slave = 8'hFF; func = 7'h7F; mode = 1'b1; first_to = TIMER_MAX; gap_to = 16'hFFFF;
        end
        default: begin
          slave    = 8'($urandom_range(0, 255));
          func     = 7'($urandom_range(0, 127));
          mode     = 1'($urandom_range(0, 1));
          first_to = 24'($urandom_range(1, 40));
          gap_to   = 16'($urandom_range(1, 40));
        end
      endcase
      write_reg(REG_EXPECTED_SLAVE, 24'(slave));
      write_reg(REG_EXPECTED_FUNCTION, 24'(func));
      write_reg(REG_FRAME_MODE, 24'(mode));
      write_reg(REG_FIRST_TIMEOUT, first_to);
      write_reg(REG_GAP_TIMEOUT, 24'(gap_to));
      goal = sent_items + 130;
      while (sent_items < goal) run_frame();
      quiesce();
    end

    if (sb.mismatches == 0 && sb.frame_outputs.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
